[rtl/core/bfce_pkg.sv]
`timescale 1ns / 1ps

package bfce_pkg;

   // Action codes carried on req_tuser.
   localparam logic [1:0] ACT_WRITE = 2'd0;
   localparam logic [1:0] ACT_READ  = 2'd1;
   localparam logic [1:0] ACT_COPY  = 2'd2;

   // Result status codes.
   localparam logic STATUS_DONE  = 1'b0;
   localparam logic STATUS_RANGE = 1'b1;

   // Beat widths, padded to whole bytes.
   localparam int REQ_TDATA_W = 56;
   localparam int RSP_TDATA_W = 16;

   typedef logic [7:0] byte_type;

endpackage

[rtl/core/bfce_mem.sv]
`timescale 1ns / 1ps

// Byte store with one write port and one registered read port.
module bfce_mem #(
   parameter int DEPTH  = 256,
   parameter int ADDR_W = 8
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_W-1:0]    wr_addr,
   input  bfce_pkg::byte_type   wr_data,
   input  logic [ADDR_W-1:0]    rd_addr,
   output bfce_pkg::byte_type   rd_data
);

   bfce_pkg::byte_type mem_ff [DEPTH];
   bfce_pkg::byte_type rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, registered.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/bit_field_copy_engine.sv]
`timescale 1ns / 1ps

// Bit field copy engine over a byte store of MEM_BYTES bytes. After reset the
// store is cleared one byte a cycle, so the block takes no beat until the whole
// store is clear. A write goes from accept through S_DONE to the result register;
// a read passes S_RDWAIT first. A copy of N bits moves one destination byte piece
// per step, and each step passes S_SRC0, S_SRC1, S_DST and S_WRITE on the single
// memory read port (low source byte, high source byte, destination byte, then the
// merged write); a refused or zero-length copy goes straight to S_DONE. One item
// is in work at a time; the result register lets the next item start while a
// result waits.
module bit_field_copy_engine #(
   parameter int MEM_BYTES = 256
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // req_tdata, from bit 0: byte_address[7:0], write_byte[7:0], source_bit[10:0],
   // dest_bit[10:0], bit_count[11:0], zero padding.
   input  logic [bfce_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // req_tuser: action[1:0].
   input  logic [1:0]                         req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // rsp_tdata, from bit 0: read_byte[7:0], status, zero padding.
   output logic [bfce_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);

   localparam int AW    = (MEM_BYTES > 2) ? $clog2(MEM_BYTES) : 1;
   localparam int LIMIT = MEM_BYTES * 8;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_CLEAR  = 3'd1;
   localparam logic [2:0] S_RDWAIT = 3'd2;
   localparam logic [2:0] S_SRC0   = 3'd3;
   localparam logic [2:0] S_SRC1   = 3'd4;
   localparam logic [2:0] S_DST    = 3'd5;
   localparam logic [2:0] S_WRITE  = 3'd6;
   localparam logic [2:0] S_DONE   = 3'd7;

   // Request fields.
   logic [7:0]  req_byte_address;
   logic [7:0]  req_write_byte;
   logic [10:0] req_source_bit;
   logic [10:0] req_dest_bit;
   logic [11:0] req_bit_count;
   logic [1:0]  req_action;

   assign req_byte_address = req_tdata[7:0];
   assign req_write_byte   = req_tdata[15:8];
   assign req_source_bit   = req_tdata[26:16];
   assign req_dest_bit     = req_tdata[37:27];
   assign req_bit_count    = req_tdata[49:38];
   assign req_action       = req_tuser;

   // Control and copy registers.
   logic [2:0]         state_ff, state_in;
   logic [AW-1:0]      clr_ff, clr_in;
   logic [11:0]        src_ff, src_in;
   logic [11:0]        dst_ff, dst_in;
   logic [11:0]        left_ff, left_in;
   bfce_pkg::byte_type lo_ff, lo_in;
   bfce_pkg::byte_type hi_ff, hi_in;
   logic               addr_ok_ff, addr_ok_in;
   bfce_pkg::byte_type res_byte_ff, res_byte_in;
   logic               res_status_ff, res_status_in;
   logic               rsp_valid_ff, rsp_valid_in;
   bfce_pkg::byte_type rsp_byte_ff, rsp_byte_in;
   logic               rsp_status_ff, rsp_status_in;

   // Memory port signals.
   logic               mem_wr_en;
   logic [AW-1:0]      mem_wr_addr;
   bfce_pkg::byte_type mem_wr_data;
   logic [AW-1:0]      mem_rd_addr;
   bfce_pkg::byte_type mem_rd_data;

   // Address and range helpers.
   logic        req_accept;
   logic        byte_in_range;
   logic        copy_too_far;
   logic [31:0] req_addr_wide;
   logic [31:0] src_byte_wide;
   logic [31:0] src_next_wide;
   logic [31:0] dst_byte_wide;

   // Piece datapath.
   logic [3:0]  room;
   logic [3:0]  piece_w;
   logic [8:0]  width_mask;
   logic [15:0] dst_mask_wide;
   logic [15:0] src_pair;
   logic [15:0] piece_wide;
   bfce_pkg::byte_type piece_val;
   bfce_pkg::byte_type dst_mask;
   bfce_pkg::byte_type merged;

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;

   assign byte_in_range = (int'(req_byte_address) < MEM_BYTES);
   assign copy_too_far  = (int'(req_source_bit) + int'(req_bit_count) > LIMIT) ||
                          (int'(req_dest_bit) + int'(req_bit_count) > LIMIT);

   assign req_addr_wide = 32'(req_byte_address);
   assign src_byte_wide = 32'(src_ff[11:3]);
   assign src_next_wide = 32'(src_ff[11:3]) + 32'd1;
   assign dst_byte_wide = 32'(dst_ff[11:3]);

   // One piece: the bits up to the end of the current destination byte, or fewer when the copy ends first.
   always_comb begin
      room          = 4'd8 - {1'b0, dst_ff[2:0]};
      piece_w       = (left_ff < 12'(room)) ? left_ff[3:0] : room;
      width_mask    = (9'd1 << piece_w) - 9'd1;
      dst_mask_wide = {8'd0, width_mask[7:0]} << dst_ff[2:0];
      dst_mask      = dst_mask_wide[7:0];
      src_pair      = {hi_ff, lo_ff} >> src_ff[2:0];
      piece_val     = src_pair[7:0] & width_mask[7:0];
      piece_wide    = {8'd0, piece_val} << dst_ff[2:0];
      merged        = (mem_rd_data & ~dst_mask) | (piece_wide[7:0] & dst_mask);
   end

   // Memory port steering per state.
   always_comb begin
      mem_wr_en   = 1'b0;
      mem_wr_addr = clr_ff;
      mem_wr_data = '0;
      mem_rd_addr = req_addr_wide[AW-1:0];
      case (state_ff)
         S_CLEAR: begin
            mem_wr_en = 1'b1;
         end
         S_IDLE: begin
            mem_wr_en   = req_accept && (req_action == bfce_pkg::ACT_WRITE) && byte_in_range;
            mem_wr_addr = req_addr_wide[AW-1:0];
            mem_wr_data = req_write_byte;
         end
         S_SRC0: begin
            mem_rd_addr = src_byte_wide[AW-1:0];
         end
         S_SRC1: begin
            mem_rd_addr = src_next_wide[AW-1:0];
         end
         S_DST: begin
            mem_rd_addr = dst_byte_wide[AW-1:0];
         end
         S_WRITE: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = dst_byte_wide[AW-1:0];
            mem_wr_data = merged;
         end
         default: begin
            mem_wr_en = 1'b0;
         end
      endcase
   end

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      src_in        = src_ff;
      dst_in        = dst_ff;
      left_in       = left_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      addr_ok_in    = addr_ok_ff;
      res_byte_in   = res_byte_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_byte_in   = rsp_byte_ff;
      rsp_status_in = rsp_status_ff;
      case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(MEM_BYTES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_accept) begin
               res_byte_in   = '0;
               res_status_in = bfce_pkg::STATUS_DONE;
               addr_ok_in    = byte_in_range;
               src_in        = {1'b0, req_source_bit};
               dst_in        = {1'b0, req_dest_bit};
               left_in       = req_bit_count;
               state_in      = S_DONE;
               if (req_action == bfce_pkg::ACT_READ) begin
                  state_in = S_RDWAIT;
               end else if (req_action == bfce_pkg::ACT_COPY) begin
                  if (copy_too_far) begin
                     res_status_in = bfce_pkg::STATUS_RANGE;
                  end else if (req_bit_count != 12'd0) begin
                     state_in = S_SRC0;
                  end
               end
            end
         end
         S_RDWAIT: begin
            res_byte_in = addr_ok_ff ? mem_rd_data : '0;
            state_in    = S_DONE;
         end
         S_SRC0: begin
            state_in = S_SRC1;
         end
         S_SRC1: begin
            lo_in    = mem_rd_data;
            state_in = S_DST;
         end
         S_DST: begin
            hi_in    = mem_rd_data;
            state_in = S_WRITE;
         end
         S_WRITE: begin
            src_in   = src_ff + 12'(piece_w);
            dst_in   = dst_ff + 12'(piece_w);
            left_in  = left_ff - 12'(piece_w);
            state_in = (left_ff == 12'(piece_w)) ? S_DONE : S_SRC0;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_byte_in   = res_byte_ff;
               rsp_status_in = res_status_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      src_ff        <= src_in;
      dst_ff        <= dst_in;
      left_ff       <= left_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      addr_ok_ff    <= addr_ok_in;
      res_byte_ff   <= res_byte_in;
      res_status_ff <= res_status_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_status_ff <= rsp_status_in;
   end

   bfce_mem #(
      .DEPTH  (MEM_BYTES),
      .ADDR_W (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_status_ff, rsp_byte_ff};

   // The store is only written while clearing, on a write beat or at a piece merge.
   a_write_states: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> (state_ff == S_CLEAR || state_ff == S_IDLE || state_ff == S_WRITE))
      else $error("store written outside a write state");

   // Every merge step consumes at least one bit of the copy.
   a_copy_progress: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WRITE) |=> (left_ff < $past(left_ff)))
      else $error("copy step made no progress");

   // A result beat only appears when the sequencer finishes an item.
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> ($past(state_ff) == S_DONE))
      else $error("result beat without a finished item");

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps

module tb;

   localparam int STORE_BYTES = 256;
   localparam int STORE_BITS  = STORE_BYTES * 8;
   // Action code 3 has no meaning; the block must leave the store alone.
   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam int MISMATCH_REPORTS = 10;

   typedef struct {
      logic [1:0]         action;
      logic [7:0]         byte_address;
      bfce_pkg::byte_type write_byte;
      logic [10:0]        source_bit;
      logic [10:0]        dest_bit;
      logic [11:0]        bit_count;
   } copy_request_type;

   typedef struct {
      bfce_pkg::byte_type read_byte;
      logic               status;
   } copy_response_type;

   logic                             clock;
   logic                             reset;
   logic                             req_tvalid;
   logic                             req_tready;
   logic [bfce_pkg::REQ_TDATA_W-1:0] req_tdata;
   logic [1:0]                       req_tuser;
   logic                             rsp_tvalid;
   logic                             rsp_tready;
   logic [bfce_pkg::RSP_TDATA_W-1:0] rsp_tdata;

   // Shadow copy of the store, updated in accept order.
   bfce_pkg::byte_type store_image [STORE_BYTES];
   copy_response_type  pending_responses [$];

   bit idling_enabled;
   int hold_off_cycles;
   int mismatch_count;
   int writes_sent;
   int reads_sent;
   int copies_sent;
   int copies_refused;
   int unused_sent;
   int copy_bits_moved;

   bit_field_copy_engine #(.MEM_BYTES(STORE_BYTES)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Hard limit on the run time.
   initial begin
      #80_000_000;
      $display("[bit_field_copy_engine] ERROR");
      $finish;
   end

   // Forward bit copy on the shadow store, one destination byte piece at a time.
   function automatic logic copy_bits_in_image(int unsigned src, int unsigned dst,
                                               int unsigned count);
      int unsigned done;
      int unsigned room;
      int unsigned width;
      int unsigned piece;
      int unsigned mask;
      int unsigned src_off;
      int unsigned dst_off;
      done = 0;
      if (src + count > STORE_BITS || dst + count > STORE_BITS) begin
         return bfce_pkg::STATUS_RANGE;
      end
      while (done < count) begin
         src_off = src % 8;
         dst_off = dst % 8;
         room    = 8 - dst_off;
         width   = (count - done < room) ? count - done : room;
         piece   = int'(store_image[src / 8]) >> src_off;
         if (width + src_off > 8) piece = piece | (int'(store_image[src / 8 + 1]) << (8 - src_off));
         piece = piece & ((1 << width) - 1);
         mask  = ((1 << width) - 1) << dst_off;
         store_image[dst / 8] = bfce_pkg::byte_type'((int'(store_image[dst / 8]) & ~mask) |
                                                     ((piece << dst_off) & mask));
         src  += width;
         dst  += width;
         done += width;
      end
      return bfce_pkg::STATUS_DONE;
   endfunction

   // Expected response of one accepted request; also advances the shadow store.
   function automatic copy_response_type predict_response(copy_request_type item);
      copy_response_type rsp;
      rsp.read_byte = '0;
      rsp.status    = bfce_pkg::STATUS_DONE;
      case (item.action)
         bfce_pkg::ACT_WRITE: begin
            store_image[item.byte_address] = item.write_byte;
            writes_sent++;
         end
         bfce_pkg::ACT_READ: begin
            rsp.read_byte = store_image[item.byte_address];
            reads_sent++;
         end
         bfce_pkg::ACT_COPY: begin
            rsp.status = copy_bits_in_image(32'(item.source_bit), 32'(item.dest_bit),
                                            32'(item.bit_count));
            copies_sent++;
            if (rsp.status == bfce_pkg::STATUS_RANGE) copies_refused++;
            else copy_bits_moved += int'(item.bit_count);
         end
         default: begin
            unused_sent++;
         end
      endcase
      return rsp;
   endfunction

   function automatic copy_request_type build_request(logic [1:0] action, int addr, int wbyte,
                                                      int src, int dst, int count);
      copy_request_type item;
      item.action       = action;
      item.byte_address = addr[7:0];
      item.write_byte   = wbyte[7:0];
      item.source_bit   = src[10:0];
      item.dest_bit     = dst[10:0];
      item.bit_count    = count[11:0];
      return item;
   endfunction

   // Random request: mostly in-range short copies and byte traffic, some noise.
   function automatic copy_request_type random_request();
      copy_request_type item;
      int unsigned pick;
      int unsigned shape;
      item.action       = bfce_pkg::ACT_WRITE;
      item.byte_address = 8'($urandom);
      item.write_byte   = 8'($urandom);
      item.source_bit   = 11'($urandom);
      item.dest_bit     = 11'($urandom);
      item.bit_count    = 12'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 30) item.action = bfce_pkg::ACT_WRITE;
      else if (pick < 58) item.action = bfce_pkg::ACT_READ;
      else if (pick < 95) item.action = bfce_pkg::ACT_COPY;
      else item.action = ACT_UNUSED;
      if (item.action == bfce_pkg::ACT_COPY) begin
         shape = $urandom_range(0, 99);
         if (shape < 80) begin
            // Short copy placed so that it fits.
            item.bit_count  = 12'($urandom_range(0, 64));
            item.source_bit = 11'($urandom_range(0, STORE_BITS - 1 - item.bit_count));
            item.dest_bit   = 11'($urandom_range(0, STORE_BITS - 1 - item.bit_count));
         end else if (shape < 85) begin
            // Short copy between nearby, often overlapping, regions.
            item.bit_count  = 12'($urandom_range(1, 48));
            item.source_bit = 11'($urandom_range(0, 1500));
            item.dest_bit   = 11'(item.source_bit + $urandom_range(0, 40));
         end else if (shape < 87) begin
            // Long copy near the start of the store.
            item.bit_count  = 12'($urandom_range(1024, 1792));
            item.source_bit = 11'($urandom_range(0, 255));
            item.dest_bit   = 11'($urandom_range(0, 255));
         end else if (shape < 95) begin
            // Short copy that usually runs off the end of the store.
            item.bit_count  = 12'($urandom_range(1, 64));
            item.source_bit = 11'($urandom_range(1990, 2047));
            item.dest_bit   = 11'($urandom_range(1990, 2047));
         end
      end
      return item;
   endfunction

   // Send one request: optional idle gap, then hold it until accepted.
   task automatic send_request(input copy_request_type item);
      int gap;
      gap = idling_enabled ? $urandom_range(0, 8) : 0;
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tuser  = item.action;
      req_tdata  = {6'b0, item.bit_count, item.dest_bit, item.source_bit,
                    item.write_byte, item.byte_address};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      pending_responses.push_back(predict_response(item));
      @(negedge clock);
   endtask

   // Stop sending and wait for every outstanding response.
   task automatic wait_for_responses();
      req_tvalid = 1'b0;
      while (pending_responses.size() > 0) @(negedge clock);
   endtask

   // Response receiver: random stalls, plus long hold-offs on request.
   initial begin
      int stall;
      rsp_tready = 1'b0;
      forever begin
         if (hold_off_cycles > 0) begin
            stall = hold_off_cycles;
            hold_off_cycles = 0;
         end else begin
            stall = idling_enabled ? $urandom_range(0, 8) : 0;
         end
         if (stall > 0) begin
            rsp_tready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready = 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         @(negedge clock);
      end
   end

   // Compare each response beat with the oldest expectation.
   always @(posedge clock) begin
      copy_response_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_responses.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MISMATCH_REPORTS)
               $display("Unexpected response beat: read_byte=%h status=%b",
                        rsp_tdata[7:0], rsp_tdata[8]);
         end else begin
            want = pending_responses.pop_front();
            if (rsp_tdata[7:0] !== want.read_byte || rsp_tdata[8] !== want.status) begin
               mismatch_count++;
               if (mismatch_count <= MISMATCH_REPORTS)
                  $display("Mismatch: expected read_byte=%h status=%b, got read_byte=%h status=%b",
                           want.read_byte, want.status, rsp_tdata[7:0], rsp_tdata[8]);
            end
         end
      end
   end

   // Byte writes and reads at the address extremes, including a cleared byte.
   task automatic test_byte_access();
      send_request(build_request(bfce_pkg::ACT_WRITE, 0, 8'hFF, 0, 0, 0));
      send_request(build_request(bfce_pkg::ACT_WRITE, 255, 8'h80, 0, 0, 0));
      send_request(build_request(bfce_pkg::ACT_WRITE, 1, 8'h00, 0, 0, 0));
      send_request(build_request(bfce_pkg::ACT_WRITE, 2, 8'h5A, 0, 0, 0));
      send_request(build_request(bfce_pkg::ACT_WRITE, 3, 8'hC3, 0, 0, 0));
      send_request(build_request(bfce_pkg::ACT_READ, 0, 0, 0, 0, 0));
      send_request(build_request(bfce_pkg::ACT_READ, 255, 0, 0, 0, 0));
      send_request(build_request(bfce_pkg::ACT_READ, 128, 8'hFF, 0, 0, 0));
      send_request(build_request(bfce_pkg::ACT_READ, 2, 0, 0, 0, 0));
   endtask

   // Copy corner cases: alignment, overlap, zero length, range limits, unused code.
   task automatic test_copy_corners();
      send_request(build_request(bfce_pkg::ACT_COPY, 0, 0, 16, 80, 16));
      send_request(build_request(bfce_pkg::ACT_COPY, 0, 0, 3, 1021, 13));
      send_request(build_request(bfce_pkg::ACT_COPY, 0, 0, 5, 7, 0));
      send_request(build_request(bfce_pkg::ACT_COPY, 0, 0, 4, 9, 30));
      send_request(build_request(bfce_pkg::ACT_COPY, 0, 0, 2047, 0, 2));
      send_request(build_request(bfce_pkg::ACT_COPY, 0, 0, 0, 2040, 9));
      send_request(build_request(bfce_pkg::ACT_COPY, 0, 0, 0, 0, 4095));
      send_request(build_request(bfce_pkg::ACT_COPY, 0, 0, 0, 0, 2048));
      send_request(build_request(bfce_pkg::ACT_COPY, 0, 0, 0, 2047, 1));
      send_request(build_request(bfce_pkg::ACT_COPY, 255, 255, 2047, 2047, 1));
      send_request(build_request(ACT_UNUSED, 255, 255, 2047, 2047, 4095));
      send_request(build_request(bfce_pkg::ACT_READ, 10, 0, 0, 0, 0));
      send_request(build_request(bfce_pkg::ACT_READ, 127, 0, 0, 0, 0));
      send_request(build_request(bfce_pkg::ACT_READ, 255, 0, 0, 0, 0));
   endtask

   task automatic test_random_traffic(input int count, input bit with_idling);
      idling_enabled = with_idling;
      repeat (count) send_request(random_request());
      idling_enabled = 1'b1;
   endtask

   // Hold off the response side while requests keep coming, so input stalls.
   task automatic test_response_backpressure();
      idling_enabled  = 1'b0;
      hold_off_cycles = 300;
      repeat (16) send_request(random_request());
      idling_enabled = 1'b1;
   endtask

   // Pause the request side until the block has gone quiet, then resume.
   task automatic test_drain_and_resume();
      wait_for_responses();
      repeat (20) send_request(random_request());
   endtask

   initial begin
      reset           = 1'b1;
      req_tvalid      = 1'b0;
      req_tdata       = '0;
      req_tuser       = bfce_pkg::ACT_WRITE;
      idling_enabled  = 1'b1;
      hold_off_cycles = 0;
      mismatch_count  = 0;
      writes_sent     = 0;
      reads_sent      = 0;
      copies_sent     = 0;
      copies_refused  = 0;
      unused_sent     = 0;
      copy_bits_moved = 0;
      foreach (store_image[i]) store_image[i] = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_byte_access();
      test_copy_corners();
      test_random_traffic(700, 1'b1);
      test_random_traffic(300, 1'b0);
      test_response_backpressure();
      test_drain_and_resume();
      test_random_traffic(350, 1'b1);

      wait_for_responses();
      repeat (40) @(posedge clock);

      $display("Covered %0d writes, %0d reads, %0d copies (%0d refused, %0d bits moved)",
               writes_sent, reads_sent, copies_sent, copies_refused, copy_bits_moved);
      $display("and %0d unused-code requests, with random stalls and a long response hold-off.",
               unused_sent);
      if (mismatch_count == 0 && pending_responses.size() == 0) begin
         $display("[bit_field_copy_engine] OK");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("[bit_field_copy_engine] ERROR");
      end
      $finish;
   end

endmodule
